[sv/vl2n_pkg.sv]
// shared types and constants for the vector l2 normalizer
package vl2n_pkg;
  localparam int VecDepth = 64;
  localparam int IdxW = $clog2(VecDepth);
  localparam int CntW = $clog2(VecDepth + 1);
  localparam int SumW = 38;
  localparam int NormW = 19;
  localparam int QuoW = 17;
  localparam int NumW = 34;
  localparam int DenW = 20;
  localparam int SqrtSteps = 20;
  localparam logic [15:0] Q15One = 16'h8000;

  typedef struct packed {
    logic [15:0] element;
    logic        is_last;
  } vl2n_in_t;

  typedef struct packed {
    logic [15:0]      scaled_element;
    logic [NormW-1:0] vector_norm;
    logic             zero_norm;
    logic             end_of_run;
  } vl2n_out_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SQRT, ST_READ, ST_DIV, ST_EMIT
  } vl2n_state_t;

  typedef struct packed {
    logic sqrt_start;
    logic sqrt_step;
    logic rd_en;
    logic div_start;
    logic div_step;
    logic emit;
    logic clear;
  } vl2n_cmd_t;

  typedef struct packed {
    logic closing;
    logic sqrt_done;
    logic div_done;
    logic zero;
    logic last_out;
  } vl2n_sts_t;
endpackage

[sv/vl2n_ctrl.sv]
// controller state machine for the normalizer
module vl2n_ctrl import vl2n_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  vl2n_sts_t sts,
  output vl2n_cmd_t cmd,
  output logic      busy
);
  vl2n_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (accept && sts.closing) state_nxt = ST_SQRT;
      ST_SQRT: if (sts.sqrt_done) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_DIV;
      ST_DIV:  if (sts.div_done || sts.zero) state_nxt = ST_EMIT;
      ST_EMIT: state_nxt = sts.last_out ? ST_LOAD : ST_READ;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_LOAD: begin
        busy = 1'b0;
        cmd.sqrt_start = accept && sts.closing;
      end
      ST_SQRT: cmd.sqrt_step = 1'b1;
      ST_READ: cmd.rd_en = 1'b1;
      ST_DIV: begin
        cmd.div_start = 1'b0;
        cmd.div_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.clear = sts.last_out;
      end
      default: busy = 1'b1;
    endcase
  end
endmodule

[sv/vl2n_dp.sv]
// datapath: element store, square sum, bitwise root and restoring divider
module vl2n_dp import vl2n_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  vl2n_in_t  in_item,
  input  vl2n_cmd_t cmd,
  output vl2n_sts_t sts,
  output vl2n_out_t out_item
);
  logic [15:0]      mem [VecDepth];
  logic [CntW-1:0]  count_r;
  logic [SumW-1:0]  sum_r;
  logic [IdxW-1:0]  rd_idx_r;
  logic [15:0]      rd_data_r;
  logic [NormW-1:0] root_r;
  logic [4:0]       bit_r;
  logic             sqrt_done_r;
  logic [NumW-1:0]  rem_r;
  logic [NumW-1:0]  num_r;
  logic [QuoW-1:0]  quo_r;
  logic [5:0]       dstep_r;
  logic [CntW-1:0]  count_nxt;
  logic [IdxW-1:0]  wr_idx;
  logic [31:0]      sq;
  logic [DenW-1:0]  trial;
  logic [2*DenW-1:0] trial_sq;
  logic [DenW-1:0]  den;
  logic [NumW-1:0]  rem_sh;
  logic [15:0]      quo_sat;

  assign wr_idx = (count_r == CntW'(VecDepth)) ? '0 : count_r[IdxW-1:0];
  assign count_nxt = CntW'(wr_idx) + 1'b1;
  assign sq = in_item.element * in_item.element;
  assign sts.closing = in_item.is_last || (count_nxt == CntW'(VecDepth));
  assign sts.sqrt_done = sqrt_done_r;
  assign sts.zero = (root_r == '0);
  assign sts.div_done = (dstep_r == 6'(NumW + 1));
  assign sts.last_out = (CntW'(rd_idx_r) + 1'b1 == count_r);

  always_ff @(posedge clk) begin
    if (accept) mem[wr_idx] <= in_item.element;
    if (cmd.rd_en) rd_data_r <= mem[rd_idx_r];
  end

  assign trial = {1'b0, root_r} | (DenW'(1) << bit_r);
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r <= '0;
      rd_idx_r <= '0;
      sqrt_done_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
        sum_r <= sum_r + SumW'(sq);
      end
      if (cmd.sqrt_start) begin
        rd_idx_r <= '0;
        sqrt_done_r <= 1'b0;
      end
      if (cmd.sqrt_step) sqrt_done_r <= (bit_r == '0);
      if (cmd.emit) rd_idx_r <= rd_idx_r + 1'b1;
      if (cmd.clear) begin
        count_r <= '0;
        sum_r <= '0;
        rd_idx_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      root_r <= '0;
      bit_r <= 5'(NormW - 1);
    end else if (cmd.sqrt_step && !sqrt_done_r) begin
      if ({(2*DenW-SumW)'(0), sum_r} >= trial_sq) root_r <= trial[NormW-1:0];
      if (bit_r != '0) bit_r <= bit_r - 1'b1;
    end
  end

  assign den = {root_r, 1'b0};
  assign rem_sh = {rem_r[NumW-2:0], num_r[NumW-1]};

  // initial step loads num, then 34 shifts consume bits 33..0
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      dstep_r <= '0;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step && !sts.div_done) begin
      if (dstep_r == '0) num_r <= NumW'({rd_data_r, 16'd0}) + NumW'(root_r);
      else begin
        num_r <= {num_r[NumW-2:0], 1'b0};
        if (rem_sh >= NumW'(den)) begin
          rem_r <= rem_sh - NumW'(den);
          quo_r <= {quo_r[QuoW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[QuoW-2:0], 1'b0};
        end
      end
      dstep_r <= (dstep_r == '0) ? 6'd1 : dstep_r + 1'b1;
    end
  end

  assign quo_sat = (quo_r > QuoW'(Q15One)) ? Q15One : quo_r[15:0];

  always_comb begin
    out_item.scaled_element = sts.zero ? 16'd0 : quo_sat;
    out_item.vector_norm = root_r;
    out_item.zero_norm = sts.zero;
    out_item.end_of_run = sts.last_out;
  end
endmodule

[sv/vector_l2_normalize.sv]
// top level of the vector l2 normalizer
// usage: drive in_item with start high while busy is low; one element is a
// transfer. an element with is_last set, or the element that fills the
// 64-entry store, closes the vector. the block then raises busy, takes the
// floor square root of the sum of squares (one root bit a cycle)
// and emits every stored element divided by the norm in q1.15, in arrival
// order, one result per out_valid pulse. each result costs one store read,
// a bit-serial divide and an emit. out_item.end_of_run marks the last
// result; busy then falls. an all-zero vector skips the divide and gives
// zero results with zero_norm set.
// the receiver cannot stall: each result stands for exactly one cycle.
// synchronous active-low reset clears the count, sum and controller state;
// the element store is not cleared.
module vector_l2_normalize import vl2n_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  vl2n_in_t  in_item,
  output logic      busy,
  output logic      out_valid,
  output vl2n_out_t out_item
);
  vl2n_cmd_t cmd;
  vl2n_sts_t sts;
  logic accept;

  assign accept = start && !busy;
  assign out_valid = cmd.emit;

  vl2n_ctrl u_ctrl (.clk, .rst_n, .accept, .sts, .cmd, .busy);
  vl2n_dp u_dp (.clk, .rst_n, .accept, .in_item, .cmd, .sts, .out_item);
endmodule

[sv/vl2n_checker.sv]
// port-level checker for the normalizer, bound to the top level
module vl2n_port_chk import vl2n_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input vl2n_out_t out_item
);
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_no_out_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> !out_valid) else $error("result during transfer");
  a_zero_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.zero_norm |-> out_item.scaled_element == '0)
    else $error("zero norm with nonzero result");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.scaled_element <= Q15One) else $error("over one");
  a_end_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.end_of_run |=> !busy) else $error("busy after end");
endmodule

bind vector_l2_normalize vl2n_port_chk u_chk (.clk, .rst_n, .start, .busy,
  .out_valid, .out_item);
